@@ rtl/core/hcbp_pkg.sv @@
// Package: types and constants shared by the Huffman code bit packer.
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int MAX_CODE_BITS = 8;
  localparam int SYM_AW        = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] symbol;
    logic [7:0] code_bits;
    logic [3:0] code_length;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  packed_byte;
    logic [3:0]  valid_bits;
    logic        final_flag;
    logic [47:0] stream_bits;
  } out_rsp_t;

  // one code table entry: length above code
  typedef struct packed {
    logic [3:0] len;
    logic [7:0] code;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/core/huffman_code_bit_packer_unit.sv @@
// Top level: Huffman code bit packer with a code table RAM and a one-byte packer.
`timescale 1ns / 1ps
`default_nettype none
// An accepted request is registered in stage 1, then its result in the output register.
// Throughput: one request per cycle unless the output is held; load, encode and flush
// may follow back to back. The code table is a 1R/1W RAM with a registered read; a
// load writes at its accept edge, so an encode of the same symbol next cycle sees it.
// Reset (rst_n low, synchronous) clears the packer, bit counter and valid flags;
// the code table is not cleared and is undefined until loaded.

module huffman_code_bit_packer_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  hcbp_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output hcbp_pkg::out_rsp_t out_data
);

  // ---------------------------------------------------------------------------
  // Stage 0: accept, table write on load, table read on any request
  // ---------------------------------------------------------------------------
  logic                            in_fire;
  logic                            sym_ok;
  logic [3:0]                      len_c;
  logic [7:0]                      mask_sh;
  hcbp_pkg::entry_t                wr_entry;
  logic [hcbp_pkg::SYM_AW-1:0]     addr;

  hcbp_pkg::entry_t code_table [hcbp_pkg::ALPHABET_SIZE];
  hcbp_pkg::entry_t rd_entry_r;

  // stage 1 request info
  logic       s1_valid_r, s1_valid_nxt;
  logic [1:0] s1_op_r;
  logic       s1_ok_r;
  logic       s1_adv;

  assign in_fire = in_valid && !in_stall;
  assign addr    = in_data.symbol[hcbp_pkg::SYM_AW-1:0];
  assign sym_ok  = ({1'b0, in_data.symbol} < 9'(hcbp_pkg::ALPHABET_SIZE));

  // clamp the length, then drop code bits above it
  always_comb begin
    len_c = (in_data.code_length > 4'(hcbp_pkg::MAX_CODE_BITS)) ?
            4'(hcbp_pkg::MAX_CODE_BITS) : in_data.code_length;
    mask_sh       = 8'hFF << len_c;
    wr_entry.len  = len_c;
    wr_entry.code = in_data.code_bits & ~mask_sh;
  end

  always_ff @(posedge clk) begin
    if (in_fire && sym_ok && (in_data.operation == hcbp_pkg::OP_LOAD)) begin
      code_table[addr] <= wr_entry;
    end
    if (in_fire) begin
      rd_entry_r <= code_table[addr];
    end
  end

  // Stage 1 moves on unless the output register is full and held.
  assign s1_adv   = s1_valid_r && !(out_valid && out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r <= in_data.operation;
      s1_ok_r <= sym_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: bit packer update using the table entry read in the accept cycle
  // ---------------------------------------------------------------------------
  logic [7:0]  partial_r, partial_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic [47:0] total_r, total_nxt;

  logic [15:0] aligned;     // code at the top of a 16-bit window
  logic [15:0] acc;
  logic [4:0]  new_fill;
  logic [48:0] total_sum;
  logic [47:0] total_sat;

  logic               res_valid;
  hcbp_pkg::out_rsp_t res;

  always_comb begin
    aligned   = {rd_entry_r.code, 8'h00} << (4'd8 - rd_entry_r.len);
    acc       = {partial_r, 8'h00} | (aligned >> fill_r);
    new_fill  = {2'b00, fill_r} + {1'b0, rd_entry_r.len};
    total_sum = {1'b0, total_r} + 49'(rd_entry_r.len);
    total_sat = total_sum[48] ? hcbp_pkg::TOTAL_MAX : total_sum[47:0];
  end

  always_comb begin
    partial_nxt     = partial_r;
    fill_nxt        = fill_r;
    total_nxt       = total_r;
    res_valid       = 1'b0;
    res.packed_byte = acc[15:8];
    res.valid_bits  = 4'd8;
    res.final_flag  = 1'b0;
    res.stream_bits = total_sat;
    if (s1_adv) begin
      unique case (s1_op_r)
        hcbp_pkg::OP_ENCODE: begin
          if (s1_ok_r && (rd_entry_r.len != 4'd0)) begin
            total_nxt = total_sat;
            if (new_fill >= 5'd8) begin
              partial_nxt = acc[7:0];
              fill_nxt    = 3'(new_fill - 5'd8);
              res_valid   = 1'b1;
            end else begin
              partial_nxt = acc[15:8];
              fill_nxt    = new_fill[2:0];
            end
          end
        end
        hcbp_pkg::OP_FLUSH: begin
          // emit the partial byte, zero padded below the filled bits
          if (fill_r != 3'd0) begin
            res_valid       = 1'b1;
            res.packed_byte = partial_r;
            res.valid_bits  = {1'b0, fill_r};
            res.final_flag  = 1'b1;
            res.stream_bits = total_r;
            partial_nxt     = 8'h00;
            fill_nxt        = 3'd0;
          end
        end
        default: begin
          // load already done in stage 0; unused code does nothing
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= 8'h00;
      fill_r    <= 3'd0;
      total_r   <= 48'd0;
    end else begin
      partial_r <= partial_nxt;
      fill_r    <= fill_nxt;
      total_r   <= total_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic out_valid_r, out_valid_nxt;
  hcbp_pkg::out_rsp_t out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = res_valid;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/core/hcbp_checker.sv @@
// Checker: port-level properties of the bit packer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input wire                out_stall,
  input hcbp_pkg::out_rsp_t out_data
);

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a held result stays and does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result dropped or changed");

  // full bytes always carry eight bits
  a_full_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.final_flag |-> out_data.valid_bits == 4'd8)
    else $error("non-final result without eight bits");

  // the final byte is a true partial byte
  a_final_partial: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.final_flag |->
      (out_data.valid_bits != 4'd0) && (out_data.valid_bits < 4'd8))
    else $error("final result with bad bit count");

  // a result that follows a taken one never shows a smaller stream bit count
  a_bits_grow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall ##1 out_valid |->
      out_data.stream_bits >= $past(out_data.stream_bits))
    else $error("stream bit count went backwards");

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
